>>> rtl/core/set_assoc_cache_lru_lookup_macros.svh
// Assertion macros shared by the cache lookup RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define SACL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define SACL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/sacl_pkg.sv
// Shared sizes, register indexes and controller commands for the cache lookup.
// Used by sacl_ctrl, sacl_dpath and set_assoc_cache_lru_lookup.
`default_nettype none

package sacl_pkg;

  // Geometry of the tag store.
  localparam int MAX_WAYS   = 8;
  localparam int MAX_SETS   = 512;
  localparam int ADDR_WIDTH = 32;

  localparam int SET_BITS       = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int MAX_INDEX_BITS = $clog2(MAX_SETS + 1) - 1;
  localparam int WAY_IDX_BITS   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TREE_LEAVES    = 1 << WAY_IDX_BITS;

  // Fixed port widths.
  localparam int CFG_WIDTH   = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int WAY_W       = 3;
  localparam int SET_W       = 9;
  localparam int COUNT_W     = 32;
  localparam int TAG_W       = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CFG_WIDTH-1:0] RESET_OFFSET_BITS = 4'd6;
  localparam logic [CFG_WIDTH-1:0] RESET_INDEX_BITS  = 4'd9;
  localparam logic [CFG_WIDTH-1:0] RESET_WAYS_IN_USE = 4'd1;

  // One row of the store holds every way of a set.
  typedef struct packed {
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
    logic [MAX_WAYS-1:0][COUNT_W-1:0] stamp;
  } row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                clear_we;
    logic [SET_BITS-1:0] clear_addr;
    logic                read_en;
    logic                update;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/sacl_ctrl.sv
// Sequencer of the cache lookup: row clearing after reset, request accept,
// result hand-off. Depends on sacl_pkg and the assertion macro header.
`default_nettype none

`include "set_assoc_cache_lru_lookup_macros.svh"

module sacl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sacl_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    CLEAR,
    IDLE,
    LOOKUP
  } state_t;

  state_t                        state;
  logic [sacl_pkg::SET_BITS-1:0] clear_cnt;
  logic                          can_load;

  // A new result may load when the output register is empty or draining.
  assign can_load = !out_valid || out_ready;
  assign in_ready = (state == IDLE);

  // Commands to the datapath.
  always_comb begin
    cmd            = '0;
    cmd.clear_addr = clear_cnt;
    cmd.clear_we   = (state == CLEAR);
    cmd.read_en    = (state == IDLE) && in_valid;
    cmd.update     = (state == LOOKUP) && can_load;
  end

  // State, clear counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      clear_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        CLEAR: begin
          clear_cnt <= clear_cnt + 1'b1;
          if (clear_cnt == sacl_pkg::SET_BITS'(sacl_pkg::MAX_SETS - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (in_valid) begin
            state <= LOOKUP;
          end
        end
        LOOKUP: begin
          if (can_load) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= CLEAR;
        end
      endcase

      if (cmd.update) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Only one request is in flight, a result is never overwritten unread,
  // and a loaded result is presented in the next cycle.
  `SACL_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)
  `SACL_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.update && out_valid, out_ready)
  `SACL_ASSERT_NEXT(a_update_shows, clk, rst, cmd.update, out_valid)
  `SACL_ASSERT_NOW(a_no_read_in_clear, clk, rst, cmd.clear_we, !cmd.read_en && !in_ready)

endmodule

`default_nettype wire

>>> rtl/core/sacl_dpath.sv
// Datapath of the cache lookup: configuration, address split, set memory,
// way compare, LRU victim tree, counters and result register. Uses sacl_pkg.
`default_nettype none

module sacl_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sacl_pkg::CFG_WIDTH-1:0]     cfg_data,
  input  wire logic [sacl_pkg::ADDR_WIDTH-1:0]    access_addr,
  input  wire sacl_pkg::cmd_t                     cmd,
  output logic                                    hit,
  output logic [sacl_pkg::WAY_W-1:0]              way,
  output logic [sacl_pkg::SET_W-1:0]              set_index,
  output logic [sacl_pkg::COUNT_W-1:0]            access_count,
  output logic [sacl_pkg::COUNT_W-1:0]            miss_count
);

  localparam int P = sacl_pkg::TREE_LEAVES;

  logic [sacl_pkg::CFG_WIDTH-1:0]    offset_bits;
  logic [sacl_pkg::CFG_WIDTH-1:0]    index_bits;
  logic [sacl_pkg::CFG_WIDTH-1:0]    ways_in_use;
  logic [sacl_pkg::CFG_WIDTH-1:0]    ib_eff;
  logic [sacl_pkg::CFG_WIDTH:0]      nways;

  logic [sacl_pkg::ADDR_WIDTH-1:0]   shifted;
  logic [sacl_pkg::SET_BITS-1:0]     set_mask;
  logic [sacl_pkg::SET_BITS-1:0]     set_in;
  logic [sacl_pkg::TAG_W-1:0]        tag_in;
  logic [sacl_pkg::SET_BITS-1:0]     set_q;
  logic [sacl_pkg::TAG_W-1:0]        tag_q;

  sacl_pkg::row_t                    mem [sacl_pkg::MAX_SETS];
  sacl_pkg::row_t                    rd_row;
  sacl_pkg::row_t                    wr_row;

  logic [sacl_pkg::MAX_WAYS-1:0]     in_use;
  logic [sacl_pkg::MAX_WAYS-1:0]     match;
  logic [sacl_pkg::MAX_WAYS-1:0]     free;
  logic [sacl_pkg::WAY_IDX_BITS-1:0] hit_way;
  logic [sacl_pkg::WAY_IDX_BITS-1:0] free_way;
  logic [sacl_pkg::WAY_IDX_BITS-1:0] victim;
  logic                              hit_any;

  logic [sacl_pkg::COUNT_W-1:0]      node_stamp [1:2*P-1];
  logic [sacl_pkg::WAY_IDX_BITS-1:0] node_way   [1:2*P-1];
  logic                              node_use   [1:2*P-1];
  logic                              take_right;

  logic [sacl_pkg::COUNT_W-1:0]      access_cnt;
  logic [sacl_pkg::COUNT_W-1:0]      miss_cnt;
  logic [sacl_pkg::COUNT_W-1:0]      access_cnt_next;
  logic [sacl_pkg::COUNT_W-1:0]      miss_cnt_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= sacl_pkg::RESET_OFFSET_BITS;
      index_bits  <= sacl_pkg::RESET_INDEX_BITS;
      ways_in_use <= sacl_pkg::RESET_WAYS_IN_USE;
    end else if (cfg_write) begin
      case (cfg_index)
        sacl_pkg::CFG_OFFSET_BITS: offset_bits <= cfg_data;
        sacl_pkg::CFG_INDEX_BITS:  index_bits  <= cfg_data;
        sacl_pkg::CFG_WAYS_IN_USE: ways_in_use <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Clamp the index width and the associativity to what the store holds.
  always_comb begin
    if (index_bits > sacl_pkg::CFG_WIDTH'(sacl_pkg::MAX_INDEX_BITS)) begin
      ib_eff = sacl_pkg::CFG_WIDTH'(sacl_pkg::MAX_INDEX_BITS);
    end else begin
      ib_eff = index_bits;
    end
    if (ways_in_use == '0) begin
      nways = (sacl_pkg::CFG_WIDTH + 1)'(1);
    end else if ({1'b0, ways_in_use} > (sacl_pkg::CFG_WIDTH + 1)'(sacl_pkg::MAX_WAYS)) begin
      nways = (sacl_pkg::CFG_WIDTH + 1)'(sacl_pkg::MAX_WAYS);
    end else begin
      nways = {1'b0, ways_in_use};
    end
  end

  // Split the address into set and tag.
  always_comb begin
    shifted = access_addr >> offset_bits;
    for (int i = 0; i < sacl_pkg::SET_BITS; i++) begin
      set_mask[i] = (i < int'(ib_eff));
    end
    set_in = sacl_pkg::SET_BITS'(shifted) & set_mask;
    tag_in = sacl_pkg::TAG_W'(shifted >> ib_eff);
  end

  // Row read on accept; the request's set and tag are held alongside.
  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      rd_row <= mem[set_in];
      set_q  <= set_in;
      tag_q  <= tag_in;
    end
  end

  // Row write: zero rows during the clearing pass, else the updated row.
  always_ff @(posedge clk) begin
    if (cmd.clear_we) begin
      mem[cmd.clear_addr] <= '0;
    end else if (cmd.update) begin
      mem[set_q] <= wr_row;
    end
  end

  // Per-way compare, first hit and first free way.
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < sacl_pkg::MAX_WAYS; w++) begin
      in_use[w] = ((sacl_pkg::CFG_WIDTH + 1)'(w) < nways);
      match[w]  = in_use[w] && rd_row.valid[w] && (rd_row.tag[w] == tag_q);
      free[w]   = in_use[w] && !rd_row.valid[w];
    end
    for (int w = sacl_pkg::MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = sacl_pkg::WAY_IDX_BITS'(w);
      end
      if (free[w]) begin
        free_way = sacl_pkg::WAY_IDX_BITS'(w);
      end
    end
    hit_any = |match;
  end

  // Oldest-stamp tree; the lower way wins a tie.
  always_comb begin
    take_right = 1'b0;
    for (int i = P; i < 2 * P; i++) begin
      if (i - P < sacl_pkg::MAX_WAYS) begin
        node_stamp[i] = rd_row.stamp[i - P];
        node_use[i]   = in_use[i - P];
      end else begin
        node_stamp[i] = '0;
        node_use[i]   = 1'b0;
      end
      node_way[i] = sacl_pkg::WAY_IDX_BITS'(i - P);
    end
    for (int i = P - 1; i >= 1; i--) begin
      take_right = node_use[2*i+1] &&
                   (!node_use[2*i] || (node_stamp[2*i+1] < node_stamp[2*i]));
      node_stamp[i] = take_right ? node_stamp[2*i+1] : node_stamp[2*i];
      node_way[i]   = take_right ? node_way[2*i+1]   : node_way[2*i];
      node_use[i]   = node_use[2*i] || node_use[2*i+1];
    end
  end

  // Victim choice, new row contents and next counter values.
  always_comb begin
    access_cnt_next = access_cnt + 1'b1;
    miss_cnt_next   = hit_any ? miss_cnt : miss_cnt + 1'b1;
    if (hit_any) begin
      victim = hit_way;
    end else if (|free) begin
      victim = free_way;
    end else begin
      victim = node_way[1];
    end
    wr_row               = rd_row;
    wr_row.stamp[victim] = access_cnt_next;
    if (!hit_any) begin
      wr_row.tag[victim]   = tag_q;
      wr_row.valid[victim] = 1'b1;
    end
  end

  // Running counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      access_cnt <= '0;
      miss_cnt   <= '0;
    end else if (cmd.update) begin
      access_cnt <= access_cnt_next;
      miss_cnt   <= miss_cnt_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit          <= hit_any;
      way          <= sacl_pkg::WAY_W'(victim);
      set_index    <= sacl_pkg::SET_W'(set_q);
      access_count <= access_cnt_next;
      miss_count   <= miss_cnt_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/set_assoc_cache_lru_lookup.sv
// Top level of the set-associative cache tag lookup with LRU replacement.
// Instantiates sacl_ctrl and sacl_dpath; uses sacl_pkg.
//
// Usage: one request carries a byte address on access_addr with
// in_valid/in_ready. Each request gives one result on out_valid/out_ready:
// hit, the way hit or filled, the set, and the running access and miss
// counts (both wrap at 32 bits).
// Timing: the set row is read when a request is accepted; compare,
// victim choice, row write-back and result load follow in lookup once
// the output register can take a result. A new request is accepted
// only in idle, after the previous one has left lookup, since its set
// row is read first and then written back.
// Reset: rst clears the counters, loads the configuration defaults and
// then clears the valid bits of all 512 set rows, one row per cycle;
// in_ready stays low until all rows are cleared. Configuration writes
// through cfg_write/cfg_index/cfg_data are taken at any time.
// Stall: a result waits in the output register while out_ready is low; a
// following request is still accepted and waits in lookup until the
// output register frees.
`default_nettype none

module set_assoc_cache_lru_lookup (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sacl_pkg::CFG_WIDTH-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [sacl_pkg::ADDR_WIDTH-1:0]    access_addr,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    hit,
  output logic [sacl_pkg::WAY_W-1:0]              way,
  output logic [sacl_pkg::SET_W-1:0]              set_index,
  output logic [sacl_pkg::COUNT_W-1:0]            access_count,
  output logic [sacl_pkg::COUNT_W-1:0]            miss_count
);

  sacl_pkg::cmd_t cmd;

  // Sequencer.
  sacl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Store, compare and counters.
  sacl_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .access_addr  (access_addr),
    .cmd          (cmd),
    .hit          (hit),
    .way          (way),
    .set_index    (set_index),
    .access_count (access_count),
    .miss_count   (miss_count)
  );

endmodule

`default_nettype wire

>>> sim/sacl_lookup_checker.sv
// Checker for the cache tag lookup: predicts every lookup result and compares.
// Depends on sacl_pkg; instantiated by tb_set_assoc_cache_lru_lookup.
`default_nettype none

module sacl_lookup_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sacl_pkg::CFG_WIDTH-1:0] cfg_data,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [sacl_pkg::ADDR_WIDTH-1:0] access_addr,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic                           hit,
  input  wire logic [sacl_pkg::WAY_W-1:0]     way,
  input  wire logic [sacl_pkg::SET_W-1:0]     set_index,
  input  wire logic [sacl_pkg::COUNT_W-1:0]   access_count,
  input  wire logic [sacl_pkg::COUNT_W-1:0]   miss_count,
  output int                                  mismatches,
  output int                                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import sacl_pkg::*;

  typedef struct packed {
    logic               hit;
    logic [WAY_W-1:0]   way;
    logic [SET_W-1:0]   set_idx;
    logic [COUNT_W-1:0] accesses;
    logic [COUNT_W-1:0] misses;
  } lookup_result_t;

  // Shadow copy of the tag store and its counters.
  logic               line_valid [MAX_SETS][MAX_WAYS];
  logic [TAG_W-1:0]   line_tag   [MAX_SETS][MAX_WAYS];
  logic [COUNT_W-1:0] line_stamp [MAX_SETS][MAX_WAYS];
  logic [COUNT_W-1:0] access_total;
  logic [COUNT_W-1:0] miss_total;

  // Shadow copy of the configuration registers.
  logic [CFG_WIDTH-1:0] cfg_offset_bits;
  logic [CFG_WIDTH-1:0] cfg_index_bits;
  logic [CFG_WIDTH-1:0] cfg_ways;

  lookup_result_t pending_lookups [$];
  int             results_seen;

  // Prints one line per wrong or unexpected result and counts it.
  task automatic report_mismatch(input string what, input lookup_result_t want,
                                 input lookup_result_t got);
    string want_s;
    string got_s;
    want_s = $sformatf("hit=%0b way=%0d set=%0d acc=%0d miss=%0d",
                       want.hit, want.way, want.set_idx, want.accesses, want.misses);
    got_s  = $sformatf("hit=%0b way=%0d set=%0d acc=%0d miss=%0d",
                       got.hit, got.way, got.set_idx, got.accesses, got.misses);
    $display("%s at result %0d: expected %s, got %s", what, results_seen, want_s, got_s);
    mismatches++;
  endtask

  // Looks one address up in the shadow store, applies the LRU update and
  // returns the result that the block must give for it.
  function automatic lookup_result_t lookup_and_update(input logic [ADDR_WIDTH-1:0] addr);
    logic [ADDR_WIDTH-1:0] shifted;
    logic [TAG_W-1:0]      tag;
    int                    ib;
    int                    nways;
    int                    set_no;
    int                    victim;
    bit                    found;
    bit                    spare;
    lookup_result_t        r;
    // Out-of-range settings are clamped, not rejected.
    ib     = (cfg_index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : int'(cfg_index_bits);
    nways  = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways));
    shifted = addr >> cfg_offset_bits;
    set_no = int'(shifted & ((32'd1 << ib) - 32'd1));
    tag    = shifted >> ib;
    access_total = access_total + 1'b1;
    found  = 1'b0;
    victim = 0;
    for (int w = 0; w < nways; w++) begin
      if (!found && line_valid[set_no][w] && line_tag[set_no][w] == tag) begin
        found  = 1'b1;
        victim = w;
      end
    end
    if (found) begin
      line_stamp[set_no][victim] = access_total;
    end else begin
      // Fill the lowest empty way first, else the oldest stamp, ties to low ways.
      spare = 1'b0;
      for (int w = 0; w < nways; w++) begin
        if (!spare && !line_valid[set_no][w]) begin
          spare  = 1'b1;
          victim = w;
        end
      end
      if (!spare) begin
        victim = 0;
        for (int w = 1; w < nways; w++) begin
          if (line_stamp[set_no][w] < line_stamp[set_no][victim]) victim = w;
        end
      end
      miss_total = miss_total + 1'b1;
      line_tag[set_no][victim]   = tag;
      line_valid[set_no][victim] = 1'b1;
      line_stamp[set_no][victim] = access_total;
    end
    r.hit      = found;
    r.way      = victim[WAY_W-1:0];
    r.set_idx  = set_no[SET_W-1:0];
    r.accesses = access_total;
    r.misses   = miss_total;
    return r;
  endfunction

  // Everything is sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    lookup_result_t want;
    lookup_result_t got;
    if (rst) begin
      for (int s = 0; s < MAX_SETS; s++) begin
        for (int w = 0; w < MAX_WAYS; w++) begin
          line_valid[s][w] = 1'b0;
          line_stamp[s][w] = '0;
        end
      end
      access_total    = '0;
      miss_total      = '0;
      cfg_offset_bits = RESET_OFFSET_BITS;
      cfg_index_bits  = RESET_INDEX_BITS;
      cfg_ways        = RESET_WAYS_IN_USE;
      pending_lookups.delete();
      results_seen    = 0;
      mismatches      = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_OFFSET_BITS: cfg_offset_bits = cfg_data;
          CFG_INDEX_BITS:  cfg_index_bits  = cfg_data;
          CFG_WAYS_IN_USE: cfg_ways        = cfg_data;
          default: ;
        endcase
      end
      // Accepted result against the oldest prediction.
      if (out_valid && out_ready) begin
        results_seen++;
        got = '{hit, way, set_index, access_count, miss_count};
        if (pending_lookups.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_lookups.pop_front();
          if (got.hit !== want.hit || got.way !== want.way ||
              got.set_idx !== want.set_idx || got.accesses !== want.accesses ||
              got.misses !== want.misses) begin
            report_mismatch("wrong result", want, got);
          end
        end
      end
      // Accepted request: predict its result now.
      if (in_valid && in_ready) begin
        pending_lookups.push_back(lookup_and_update(access_addr));
      end
    end
    outstanding = pending_lookups.size();
  end

endmodule

`default_nettype wire

>>> sim/tb_set_assoc_cache_lru_lookup.sv
// Testbench top for the cache tag lookup: clock, reset, requests and verdict.
// Depends on sacl_pkg, set_assoc_cache_lru_lookup and sacl_lookup_checker.
`default_nettype none

module tb_set_assoc_cache_lru_lookup;
  timeunit 1ns;
  timeprecision 1ps;
  import sacl_pkg::*;

  localparam int REQUEST_GOAL     = 550;
  localparam int PHASES           = 12;
  localparam int CYCLE_LIMIT      = 150000;
  localparam int LONG_HOLD_AT     = 60;
  localparam int LONG_HOLD_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_WIDTH-1:0]  cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [ADDR_WIDTH-1:0] access_addr;
  logic                  out_valid;
  logic                  out_ready;
  logic                  hit;
  logic [WAY_W-1:0]      way;
  logic [SET_W-1:0]      set_index;
  logic [COUNT_W-1:0]    access_count;
  logic [COUNT_W-1:0]    miss_count;
  int                    mismatches;
  int                    outstanding;

  // Current settings and the working set that random requests aim at.
  logic [CFG_WIDTH-1:0] cur_offset;
  logic [CFG_WIDTH-1:0] cur_index;
  logic [CFG_WIDTH-1:0] cur_ways;
  int                   cur_ib;
  logic [TAG_W-1:0]     hot_tags [12];
  logic [31:0]          hot_sets [3];
  int                   hot_tag_count;
  int                   hot_set_count;
  bit                   quiet_sender;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_assoc_cache_lru_lookup dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .access_addr(access_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .way(way), .set_index(set_index),
    .access_count(access_count), .miss_count(miss_count)
  );

  sacl_lookup_checker lookup_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .access_addr(access_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .way(way), .set_index(set_index),
    .access_count(access_count), .miss_count(miss_count),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // Writes all three registers on consecutive cycles; called at a falling edge.
  task automatic program_cache(input logic [CFG_WIDTH-1:0] off,
                               input logic [CFG_WIDTH-1:0] idx,
                               input logic [CFG_WIDTH-1:0] nw);
    cfg_write <= 1'b1;
    cfg_index <= CFG_OFFSET_BITS;
    cfg_data  <= off;
    @(negedge clk);
    cfg_index <= CFG_INDEX_BITS;
    cfg_data  <= idx;
    @(negedge clk);
    cfg_index <= CFG_WAYS_IN_USE;
    cfg_data  <= nw;
    @(negedge clk);
    cfg_write  <= 1'b0;
    cur_offset = off;
    cur_index  = idx;
    cur_ways   = nw;
    cur_ib     = (idx > MAX_INDEX_BITS) ? MAX_INDEX_BITS : int'(idx);
  endtask

  // Offers one request after a random gap (none when the sender is quiet) and holds it until accepted.
  task automatic send_request(input logic [ADDR_WIDTH-1:0] addr);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    access_addr <= addr;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // One to three sets and up to three more tags than ways, so that lines get evicted.
  task automatic plan_working_set;
    int nways;
    nways = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : int'(cur_ways));
    hot_set_count = $urandom_range(1, 3);
    hot_tag_count = nways + $urandom_range(0, 3);
    for (int i = 0; i < hot_set_count; i++) hot_sets[i] = $urandom_range(0, (1 << cur_ib) - 1);
    for (int i = 0; i < hot_tag_count; i++) hot_tags[i] = $urandom;
  endtask

  // Mostly working-set addresses with random block offsets, some pure noise.
  function automatic logic [ADDR_WIDTH-1:0] pick_address();
    logic [63:0] a;
    if ($urandom_range(0, 4) == 0) return $urandom;
    a = {32'd0, hot_tags[$urandom_range(0, hot_tag_count - 1)]} << (cur_offset + cur_ib);
    a = a | ({32'd0, hot_sets[$urandom_range(0, hot_set_count - 1)]} << cur_offset);
    a = a | ({32'd0, $urandom} & ((64'd1 << cur_offset) - 64'd1));
    return a[ADDR_WIDTH-1:0];
  endfunction

  // Result side: random stalls, calm stretches, and one long hold-off that
  // lets the block fill up and stall its request side.
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (taken == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
      else if ((taken / 40) % 3 == 2) hold = 0;
      else hold = $urandom_range(0, 16);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  // Run limit.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int per_phase;
    logic [CFG_WIDTH-1:0] off;
    logic [CFG_WIDTH-1:0] idx;
    logic [CFG_WIDTH-1:0] nw;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = CFG_OFFSET_BITS;
    cfg_data     = '0;
    in_valid     = 1'b0;
    access_addr  = '0;
    out_ready    = 1'b0;
    quiet_sender = 1'b0;
    cur_offset   = RESET_OFFSET_BITS;
    cur_index    = RESET_INDEX_BITS;
    cur_ways     = RESET_WAYS_IN_USE;
    cur_ib       = MAX_INDEX_BITS;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: cold miss, hits in the same block, top address,
    // and a conflict in a direct-mapped set.
    send_request(32'h0000_0000);
    send_request(32'h0000_0000);
    send_request(32'h0000_003F);
    send_request(32'hFFFF_FFFF);
    send_request(32'h0000_8000);
    send_request(32'h0000_0000);

    // Offset past the usual range, index wider than the store, zero ways.
    // The store is not flushed, so old entries stay visible.
    drain();
    program_cache(4'd15, 4'd15, 4'd0);
    send_request(32'hFFFF_FFFF);
    send_request(32'h8000_0000);
    send_request(32'hFFFF_FFFF);
    send_request(32'h0000_0000);

    // One set of eight ways: fill it, evict the oldest, refresh, evict again.
    drain();
    program_cache(4'd0, 4'd0, 4'd8);
    for (int k = 1; k <= 9; k++) send_request(ADDR_WIDTH'(k));
    send_request(32'd2);
    send_request(32'd1);

    // Ways above the maximum act as the maximum.
    drain();
    program_cache(4'd12, 4'd9, 4'd15);
    send_request(32'hFFFF_F000);
    send_request(32'h0000_1000);
    send_request(32'hFFFF_F000);

    // Random phases, each under its own settings, extremes first.
    per_phase = REQUEST_GOAL / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin off = 4'd0;  idx = 4'd0;  nw = 4'd1; end
        1: begin off = 4'd12; idx = 4'd9;  nw = 4'd8; end
        2: begin off = 4'd4;  idx = 4'd2;  nw = 4'd4; end
        3: begin off = 4'd6;  idx = 4'd3;  nw = 4'd8; end
        4: begin off = 4'd15; idx = 4'd9;  nw = 4'd8; end
        5: begin off = 4'd13; idx = 4'd11; nw = 4'd9; end
        6: begin off = 4'd2;  idx = 4'd0;  nw = 4'd2; end
        7: begin off = 4'd5;  idx = 4'd1;  nw = 4'd0; end
        8: begin off = 4'd6;  idx = 4'd9;  nw = 4'd1; end
        default: begin
          off = CFG_WIDTH'($urandom_range(0, 15));
          idx = CFG_WIDTH'($urandom_range(0, 15));
          nw  = CFG_WIDTH'($urandom_range(0, 15));
        end
      endcase
      drain();
      program_cache(off, idx, nw);
      plan_working_set();
      quiet_sender = (p % 3 == 1);
      for (int n = 0; n < per_phase; n++) begin
        if (n % 16 == 15) plan_working_set();
        send_request(pick_address());
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
